// File: sv/als_pkg.sv
`timescale 1ns / 1ps
package als_pkg;

  // word and field widths, commands, states and control/status structs
  localparam int IN_W   = 104;
  localparam int OUT_W  = 24;
  localparam int CRD_W  = 16;
  localparam int DIF_W  = 17;
  localparam int SQ_W   = 33;
  localparam int RT_W   = 34;
  localparam int N_W    = 14;
  localparam int DVD_W  = 20;
  localparam int Q_W    = 22;
  localparam int POS_W  = 23;
  localparam int PIX_W  = 16;
  localparam int WGT_W  = 9;
  localparam int ADD_W  = 13;
  localparam int ACC_W  = 16;
  localparam int ENT_W  = 48;
  localparam int SQ_ITERS = 17;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SQINIT,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_SAMPLE,
    ST_PW,
    ST_PM,
    ST_PA,
    ST_STEP,
    ST_RREAD,
    ST_RWAIT
  } state_t;

  typedef struct packed {
    logic       clr_en;
    logic       load;
    logic       sq_mul;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       divx_start;
    logic       divy_start;
    logic       cap_x;
    logic       cap_y;
    logic       sample;
    logic       step;
    logic       pix_w;
    logic       pix_m;
    logic       pix_a;
    logic [1:0] pix;
    logic       rd_issue;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sqrt_done;
    logic div_done;
    logic sample_last;
    logic out_free;
  } status_t;

endpackage

// File: sv/antialiased_line_splat.sv
`timescale 1ns / 1ps
// A read word passes RREAD (frame store read) and RWAIT (result registered once the output is free) before m_tvalid.
// Draw word: n = max(1, floor(2*length)) gives n+1 samples; busy through
//   the 17-step square root, two 20-step shared divisions and 4 read-modify-writes per sample.
// Throughput: one word at a time; next word is taken once the previous one is done.
// Reset (rst, sync, active high) clears control, then a clearing pass zeroes the frame
//   store, one entry a cycle over all IMAGE_WIDTH*IMAGE_HEIGHT entries with s_tready low.
module antialiased_line_splat #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  // tdata, low bit up: start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48],
  //   red[71:64], green[79:72], blue[87:80], read_col[95:88], read_row[103:96]
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [als_pkg::IN_W-1:0]   s_tdata,
  input  logic                       s_tuser,  // command: 0 draw, 1 read
  // tdata, low bit up: pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [als_pkg::OUT_W-1:0]  m_tdata
);
  import als_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequencer: clear pass, sqrt, divisions, per-sample splat loop, reads
  als_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tuser (s_tuser),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // arithmetic, step accumulators, frame store and output register
  als_dpath #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .in_data (s_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_tdata (m_tdata)
  );

endmodule

// File: sv/als_div.sv
`timescale 1ns / 1ps
module als_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [als_pkg::DVD_W-1:0]  dividend,
  input  logic [als_pkg::N_W-1:0]    divisor,
  output logic [als_pkg::DVD_W-1:0]  quo,
  output logic [als_pkg::N_W-1:0]    rem,
  output logic                       done
);
  import als_pkg::*;

  // restoring divider, one quotient bit per cycle
  logic [4:0]       cnt;
  logic [N_W-1:0]   dvs;
  logic [N_W:0]     rsh;
  logic             ge;

  assign rsh = {rem, quo[DVD_W-1]};
  assign ge  = (rsh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= 5'(DVD_W);
      done <= 1'b0;
    end else begin
      done <= (cnt == 5'd1);
      if (cnt != '0) cnt <= cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= ge ? N_W'(rsh - {1'b0, dvs}) : rsh[N_W-1:0];
    end
  end

endmodule

// File: sv/als_dpath.sv
`timescale 1ns / 1ps
module als_dpath #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [als_pkg::IN_W-1:0]  in_data,
  input  als_pkg::cmd_t             cmd,
  output als_pkg::status_t          sts,
  input  logic                      m_tready,
  output logic                      m_tvalid,
  output logic [als_pkg::OUT_W-1:0] m_tdata
);
  import als_pkg::*;

  localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(IMAGE_WIDTH);
  localparam int YW    = $clog2(IMAGE_HEIGHT);

  // unpack input word
  logic signed [CRD_W-1:0] in_sx, in_sy, in_ex, in_ey;
  assign in_sx = in_data[15:0];
  assign in_sy = in_data[31:16];
  assign in_ex = in_data[47:32];
  assign in_ey = in_data[63:48];

  logic signed [CRD_W-1:0] x0, y0;
  logic signed [DIF_W-1:0] dx, dy;
  logic [7:0] cr, cg, cb, rd_col, rd_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0     <= in_sx;
      y0     <= in_sy;
      dx     <= DIF_W'(in_ex) - DIF_W'(in_sx);
      dy     <= DIF_W'(in_ey) - DIF_W'(in_sy);
      cr     <= in_data[71:64];
      cg     <= in_data[79:72];
      cb     <= in_data[87:80];
      rd_col <= in_data[95:88];
      rd_row <= in_data[103:96];
    end
  end

  // squared length
  logic [SQ_W-1:0] sqx, sqy;
  logic signed [2*DIF_W-1:0] px2, py2;
  assign px2 = (2*DIF_W)'(dx) * (2*DIF_W)'(dx);
  assign py2 = (2*DIF_W)'(dy) * (2*DIF_W)'(dy);

  always_ff @(posedge clk) begin
    if (cmd.sq_mul) begin
      sqx <= px2[SQ_W-1:0];
      sqy <= py2[SQ_W-1:0];
    end
  end

  // bit-pair integer square root
  logic [SQ_W-1:0] sq_v, sq_bit;
  logic [RT_W-1:0] sq_res, sq_try;
  logic [4:0]      sq_cnt;
  assign sq_try = sq_res + RT_W'(sq_bit);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (cmd.sqrt_init) begin
      sq_cnt <= 5'(SQ_ITERS);
    end else if (cmd.sqrt_step && sq_cnt != '0) begin
      sq_cnt <= sq_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_v   <= sqx + sqy;
      sq_res <= '0;
      sq_bit <= SQ_W'(1) << (SQ_W - 1);
    end else if (cmd.sqrt_step && sq_cnt != '0) begin
      if ({1'b0, sq_v} >= sq_try) begin
        sq_v   <= sq_v - sq_try[SQ_W-1:0];
        sq_res <= (sq_res >> 1) + RT_W'(sq_bit);
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // step count n = max(1, floor(2*length)), giving n+1 samples
  logic [N_W-1:0] n_comb, n_reg;
  assign n_comb = (sq_res[16:3] == '0) ? N_W'(1) : sq_res[16:3];

  // per-axis step, shared divider
  logic [15:0]      absx, absy;
  logic [DVD_W-1:0] div_a, div_q;
  logic [N_W-1:0]   div_d, div_r;
  logic             div_done;
  assign absx  = dx[DIF_W-1] ? 16'(-dx) : dx[15:0];
  assign absy  = dy[DIF_W-1] ? 16'(-dy) : dy[15:0];
  assign div_a = cmd.divx_start ? {absx, 4'b0} : {absy, 4'b0};
  assign div_d = cmd.divx_start ? n_comb : n_reg;

  als_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.divx_start | cmd.divy_start),
    .dividend(div_a),
    .divisor (div_d),
    .quo     (div_q),
    .rem     (div_r),
    .done    (div_done)
  );

  logic signed [Q_W-1:0] qstep_x, qstep_y, qx, qy, qs_new;
  logic [N_W-1:0]        rstep_x, rstep_y, rx, ry, rs_new;
  logic [N_W-1:0]        cnt;
  logic                  neg;

  // floor division of the signed step
  always_comb begin
    neg = cmd.cap_x ? dx[DIF_W-1] : dy[DIF_W-1];
    if (!neg) begin
      qs_new = Q_W'(div_q);
      rs_new = div_r;
    end else if (div_r == '0) begin
      qs_new = -Q_W'(div_q);
      rs_new = '0;
    end else begin
      qs_new = -Q_W'(div_q) - Q_W'(1);
      rs_new = n_reg - div_r;
    end
  end

  logic [N_W:0] rx_sum, ry_sum;
  logic         wrap_x, wrap_y;
  assign rx_sum = {1'b0, rx} + {1'b0, rstep_x};
  assign ry_sum = {1'b0, ry} + {1'b0, rstep_y};
  assign wrap_x = rx_sum >= {1'b0, n_reg};
  assign wrap_y = ry_sum >= {1'b0, n_reg};

  always_ff @(posedge clk) begin
    if (cmd.divx_start) n_reg <= n_comb;
    if (cmd.cap_x) begin
      qstep_x <= qs_new;
      rstep_x <= rs_new;
    end
    if (cmd.cap_y) begin
      qstep_y <= qs_new;
      rstep_y <= rs_new;
      qx  <= '0;
      qy  <= '0;
      rx  <= '0;
      ry  <= '0;
      cnt <= '0;
    end else if (cmd.step) begin
      qx  <= wrap_x ? qx + qstep_x + Q_W'(1) : qx + qstep_x;
      rx  <= wrap_x ? N_W'(rx_sum - {1'b0, n_reg}) : rx_sum[N_W-1:0];
      qy  <= wrap_y ? qy + qstep_y + Q_W'(1) : qy + qstep_y;
      ry  <= wrap_y ? N_W'(ry_sum - {1'b0, n_reg}) : ry_sum[N_W-1:0];
      cnt <= cnt + N_W'(1);
    end
  end

  // sample point: Q.8 position, pixel and fraction
  logic signed [POS_W-1:0] pos_x, pos_y;
  logic signed [PIX_W-1:0] xi, yi;
  logic [7:0]              fx, fy;
  assign pos_x = {{3{x0[CRD_W-1]}}, x0, 4'b0} + {qx[Q_W-1], qx};
  assign pos_y = {{3{y0[CRD_W-1]}}, y0, 4'b0} + {qy[Q_W-1], qy};

  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      xi <= {pos_x[POS_W-1], pos_x[POS_W-1:8]};
      yi <= {pos_y[POS_W-1], pos_y[POS_W-1:8]};
      fx <= pos_x[7:0];
      fy <= pos_y[7:0];
    end
  end

  // one corner of the 2x2 splat
  logic signed [PIX_W-1:0] px, py;
  logic [WGT_W-1:0]        wx, wy, weight;
  logic [2*WGT_W-1:0]      wprod;
  logic                    p_ok, pix_ok;
  logic [AW-1:0]           p_addr, pix_addr, rd_addr, clr_cnt;
  logic                    rd_ok;

  assign px    = xi + PIX_W'(cmd.pix[0]);
  assign py    = yi + PIX_W'(cmd.pix[1]);
  assign wx    = cmd.pix[0] ? {1'b0, fx} : WGT_W'(256) - {1'b0, fx};
  assign wy    = cmd.pix[1] ? {1'b0, fy} : WGT_W'(256) - {1'b0, fy};
  assign wprod = (2*WGT_W)'(wx) * (2*WGT_W)'(wy);
  assign p_ok  = !px[PIX_W-1] && (px < PIX_W'(IMAGE_WIDTH)) &&
                 !py[PIX_W-1] && (py < PIX_W'(IMAGE_HEIGHT));
  assign p_addr = AW'(32'(py[YW-1:0]) * IMAGE_WIDTH + 32'(px[XW-1:0]));

  assign rd_ok   = (13'(rd_col) < 13'(IMAGE_WIDTH)) && (13'(rd_row) < 13'(IMAGE_HEIGHT));
  assign rd_addr = AW'(32'(rd_row) * IMAGE_WIDTH + 32'(rd_col));

  logic [ADD_W-1:0] add_r, add_g, add_b;
  logic [16:0]      mr, mg, mb;
  assign mr = 17'(cr) * 17'(weight);
  assign mg = 17'(cg) * 17'(weight);
  assign mb = 17'(cb) * 17'(weight);

  always_ff @(posedge clk) begin
    if (cmd.pix_w) begin
      pix_ok   <= p_ok;
      pix_addr <= p_addr;
      weight   <= wprod[16:8];
    end
    if (cmd.pix_m) begin
      add_r <= mr[16:4];
      add_g <= mg[16:4];
      add_b <= mb[16:4];
    end
  end

  // frame store
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata, wdata, sum_ent;
  logic [AW-1:0]    waddr, raddr;
  logic             we, re;

  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a, logic [ADD_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + (ACC_W+1)'(b);
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

  assign sum_ent = {sat_add(rdata[47:32], add_b), sat_add(rdata[31:16], add_g),
                    sat_add(rdata[15:0], add_r)};
  assign we    = cmd.clr_en | (cmd.pix_a & pix_ok);
  assign waddr = cmd.clr_en ? clr_cnt : pix_addr;
  assign wdata = cmd.clr_en ? '0 : sum_ent;
  assign re    = cmd.pix_w | cmd.rd_issue;
  assign raddr = cmd.pix_w ? p_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // result word
  function automatic logic [7:0] clamp8(logic [ACC_W-1:0] a);
    return (a[15:12] != '0) ? 8'hFF : a[11:4];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= rd_ok ? {clamp8(rdata[47:32]), clamp8(rdata[31:16]), clamp8(rdata[15:0])}
                       : '0;
    end
  end

  assign sts.clr_last    = (clr_cnt == AW'(DEPTH - 1));
  assign sts.sqrt_done   = (sq_cnt == '0);
  assign sts.div_done    = div_done;
  assign sts.sample_last = (cnt == n_reg);
  assign sts.out_free    = !m_tvalid || m_tready;

endmodule

// File: sv/als_ctrl.sv
`timescale 1ns / 1ps
module als_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tuser,
  output logic              s_tready,
  input  als_pkg::status_t  sts,
  output als_pkg::cmd_t     cmd
);
  import als_pkg::*;

  state_t     state, state_next;
  logic [1:0] pix, pix_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pix   <= '0;
    end else begin
      state <= state_next;
      pix   <= pix_next;
    end
  end

  always_comb begin
    state_next = state;
    pix_next   = pix;
    cmd        = '0;
    cmd.pix    = pix;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = (s_tuser == CMD_READ) ? ST_RREAD : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.sq_mul = 1'b1;
        state_next = ST_SQINIT;
      end
      ST_SQINIT: begin
        cmd.sqrt_init = 1'b1;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) begin
          cmd.divx_start = 1'b1;
          state_next     = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (sts.div_done) begin
          cmd.cap_x      = 1'b1;
          cmd.divy_start = 1'b1;
          state_next     = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (sts.div_done) begin
          cmd.cap_y  = 1'b1;
          state_next = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        cmd.sample = 1'b1;
        pix_next   = '0;
        state_next = ST_PW;
      end
      ST_PW: begin
        cmd.pix_w  = 1'b1;
        state_next = ST_PM;
      end
      ST_PM: begin
        cmd.pix_m  = 1'b1;
        state_next = ST_PA;
      end
      ST_PA: begin
        cmd.pix_a = 1'b1;
        pix_next  = pix + 2'd1;
        state_next = (pix == 2'd3) ? ST_STEP : ST_PW;
      end
      ST_STEP: begin
        if (sts.sample_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_SAMPLE;
        end
      end
      ST_RREAD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: sv/als_chk.sv
`timescale 1ns / 1ps
module als_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [als_pkg::OUT_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input ready during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

endmodule

bind antialiased_line_splat als_chk u_als_chk (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// File: tb/tb_antialiased_line_splat.sv
`timescale 1ns / 1ps
module tb_antialiased_line_splat;
  import als_pkg::*;

  localparam int IMG_W     = 256;
  localparam int IMG_H     = 256;
  localparam int N_RANDOM  = 1630;
  localparam int HOLD_AT   = 900;      // sender drains outstanding reads here
  localparam longint LIMIT = 4000000;  // clear pass + worst-case long segments, with margin

  typedef struct {
    logic        cmd;
    logic [15:0] sx, sy, ex, ey;
    logic [7:0]  red, green, blue;
    logic [7:0]  col, row;
  } seg_word_t;

  typedef struct {
    logic [7:0] red, green, blue;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  seg_word_t word_q[$];
  seg_word_t cur_word;
  pixel_t    pixel_q[$];
  bit [15:0] accum [0:IMG_W*IMG_H-1][0:2];  // bit type: starts cleared
  longint    cyc = 0;
  int        sent = 0;
  int        errs = 0;

  antialiased_line_splat #(.IMAGE_WIDTH(IMG_W), .IMAGE_HEIGHT(IMG_H)) dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void splat_pixel(longint px, longint py, int w, seg_word_t s);
    int idx, sum;
    int clr[3];
    if (px < 0 || px >= IMG_W || py < 0 || py >= IMG_H) return;
    idx = int'(py) * IMG_W + int'(px);
    clr[0] = int'(s.red); clr[1] = int'(s.green); clr[2] = int'(s.blue);
    for (int c = 0; c < 3; c++) begin
      sum = int'(accum[idx][c]) + ((clr[c] * w) >> 4);
      accum[idx][c] = (sum > 65535) ? 16'hFFFF : sum[15:0];
    end
  endfunction

  function automatic void draw_segment(seg_word_t s);
    longint x0, y0, dx, dy, n, xs, ys, xi, yi;
    int fx, fy;
    int wx[2], wy[2];
    x0 = longint'($signed(s.sx));
    y0 = longint'($signed(s.sy));
    dx = longint'($signed(s.ex)) - x0;
    dy = longint'($signed(s.ey)) - y0;
    n = longint'(int_sqrt(longint'(dx * dx + dy * dy)) >> 3);
    if (n < 1) n = 1;
    for (longint i = 0; i <= n; i++) begin
      xs = x0 * 16 + floor_quot(dx * 16 * i, n);
      ys = y0 * 16 + floor_quot(dy * 16 * i, n);
      xi = floor_quot(xs, 256);
      yi = floor_quot(ys, 256);
      fx = int'(xs - xi * 256);
      fy = int'(ys - yi * 256);
      wx[0] = 256 - fx; wx[1] = fx;
      wy[0] = 256 - fy; wy[1] = fy;
      for (int oy = 0; oy < 2; oy++)
        for (int ox = 0; ox < 2; ox++)
          splat_pixel(xi + ox, yi + oy, (wx[ox] * wy[oy]) >> 8, s);
    end
  endfunction

  function automatic void apply_word(seg_word_t s);
    pixel_t p;
    int idx;
    int v[3];
    if (s.cmd == CMD_DRAW) begin
      draw_segment(s);
    end else begin
      idx = int'(s.row) * IMG_W + int'(s.col);
      for (int c = 0; c < 3; c++) begin
        v[c] = int'(accum[idx][c] >> 4);
        if (v[c] > 255) v[c] = 255;
      end
      p.red = 8'(v[0]); p.green = 8'(v[1]); p.blue = 8'(v[2]);
      pixel_q = {pixel_q, p};
    end
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic void queue_word(seg_word_t s);
    word_q = {word_q, s};
  endfunction

  function automatic logic [15:0] clamp_q4(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic seg_word_t line_word(int sx, int sy, int ex, int ey,
                                          int r, int g, int b);
    seg_word_t s;
    s.cmd = CMD_DRAW;
    s.sx = clamp_q4(sx); s.sy = clamp_q4(sy);
    s.ex = clamp_q4(ex); s.ey = clamp_q4(ey);
    s.red = 8'(r); s.green = 8'(g); s.blue = 8'(b);
    s.col = 8'($urandom); s.row = 8'($urandom);  // ignored on a draw
    return s;
  endfunction

  function automatic seg_word_t read_word(int c, int r);
    seg_word_t s;
    s.cmd = CMD_READ;
    s.sx = 16'($urandom); s.sy = 16'($urandom); s.ex = 16'($urandom); s.ey = 16'($urandom);
    s.red = 8'($urandom); s.green = 8'($urandom); s.blue = 8'($urandom);
    s.col = 8'(c); s.row = 8'(r);
    return s;
  endfunction

  function automatic seg_word_t random_word();
    int sx, sy, pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // reads: half in the busy patch, half anywhere
      if ($urandom_range(1))
        return read_word($urandom_range(112, 96), $urandom_range(112, 96));
      return read_word($urandom_range(255), $urandom_range(255));
    end else if (pick < 60) begin
      // busy patch: repeated splats push accumulators into saturation
      sx = $urandom_range(112 * 16, 96 * 16);
      sy = $urandom_range(112 * 16, 96 * 16);
    end else if (pick < 90) begin
      // anywhere on or just around the image
      sx = $urandom_range(264 * 16) - 64;
      sy = $urandom_range(264 * 16) - 64;
    end else begin
      // full-range endpoints, short span
      sx = $signed(16'($urandom));
      sy = $signed(16'($urandom));
    end
    return line_word(sx, sy, sx + $urandom_range(160) - 80, sy + $urandom_range(160) - 80,
                     $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endfunction

  // no idling inside the quiet window
  function automatic bit idle_now();
    return (sent < 1200 || sent > 1400) && ($urandom_range(99) < 9);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin : drive
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_word(cur_word);
        sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (word_q.size() != 0 && !idle_now() &&
            !(sent == HOLD_AT && pixel_q.size() != 0)) begin
          cur_word = word_q.pop_front();
          s_tdata <= {cur_word.row, cur_word.col, cur_word.blue, cur_word.green,
                      cur_word.red, cur_word.ey, cur_word.ex, cur_word.sy, cur_word.sx};
          s_tuser <= cur_word.cmd;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin : watch
    pixel_t want;
    cyc++;
    m_tready <= rst ? 1'b0 : !idle_now();
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel word %h", m_tdata);
        errs++;
      end else begin
        want = pixel_q.pop_front();
        if (m_tdata[7:0] !== want.red) begin
          $error("pixel_red: expected %0d, got %0d", want.red, m_tdata[7:0]);
          errs++;
        end
        if (m_tdata[15:8] !== want.green) begin
          $error("pixel_green: expected %0d, got %0d", want.green, m_tdata[15:8]);
          errs++;
        end
        if (m_tdata[23:16] !== want.blue) begin
          $error("pixel_blue: expected %0d, got %0d", want.blue, m_tdata[23:16]);
          errs++;
        end
      end
    end
    if (cyc > LIMIT) begin
      $display("tb_antialiased_line_splat: errors");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    // directed: corners, zero length, off image, long spans, saturation
    queue_word(read_word(0, 0));
    queue_word(line_word(0, 0, 0, 0, 255, 255, 255));  // zero length at pixel 0,0
    queue_word(read_word(0, 0));
    queue_word(line_word(255 * 16 + 8, 255 * 16 + 8, 255 * 16 + 8, 255 * 16 + 8,
                         255, 0, 128));  // straddles the far corner
    queue_word(read_word(255, 255));
    queue_word(line_word(-2000, -2000, -1900, -1990, 255, 255, 255));  // off image
    queue_word(line_word(-160, -160, 270 * 16, 270 * 16, 17, 200, 90));  // diagonal
    queue_word(read_word(128, 128));
    queue_word(line_word(-32768, -32768, 32767, 32767, 1, 2, 3));  // widest span
    queue_word(line_word(32767, -32768, 32767 - 8, -32768 + 8, 0, 0, 0));
    for (int k = 0; k < 10; k++)  // drive one pixel into saturation
      queue_word(line_word(50 * 16, 60 * 16, 50 * 16, 60 * 16, 255, 255, 255));
    queue_word(read_word(50, 60));
    queue_word(read_word(51, 60));
    queue_word(line_word(10 * 16 + 5, 20 * 16 + 11, 14 * 16 + 3, 17 * 16 + 1,
                         128, 64, 32));
    queue_word(read_word(11, 19));
    for (int k = 0; k < N_RANDOM; k++)
      queue_word(random_word());

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (word_q.size() == 0 && !s_tvalid && pixel_q.size() == 0);
    repeat (2000) @(posedge clk);
    if (errs == 0 && pixel_q.size() == 0)
      $display("tb_antialiased_line_splat: clean");
    else
      $display("tb_antialiased_line_splat: errors");
    $finish;
  end

endmodule

// File: files.f
sv/als_pkg.sv
sv/als_div.sv
sv/als_dpath.sv
sv/als_ctrl.sv
sv/antialiased_line_splat.sv
sv/als_chk.sv
tb/tb_antialiased_line_splat.sv
